FILE: hw/rtl/rgh_pkg.sv
// Shared constants, codes and word types for the regular grid histogram.
// Used by every module of the block; depends on nothing.
package rgh_pkg;

  localparam int MAX_BINS    = 4096;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int BIN_COUNT_W = BIN_W + 1;
  localparam int COUNT_W     = 32;
  localparam int SAMPLE_W    = 32;
  localparam int EDGE_W      = 32;
  localparam int IW_W        = 32;
  localparam int STEP_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int OUT_DEPTH   = 2;
  localparam int OUT_AW      = $clog2(OUT_DEPTH);

  localparam logic [COUNT_W-1:0]     CNT_MAX        = {COUNT_W{1'b1}};
  localparam logic [BIN_COUNT_W-1:0] MAX_BINS_C     = BIN_COUNT_W'(MAX_BINS);
  localparam logic signed [EDGE_W-1:0] START_RST    = '0;
  localparam logic signed [EDGE_W-1:0] END_RST      = EDGE_W'(268435456);
  localparam logic [IW_W-1:0]        IW_RST         = IW_W'(65536);
  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST  = BIN_COUNT_W'(4096);
  localparam logic [STEP_W-1:0]      STEP_RST       = STEP_W'(1);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_START   = 3'd0,
    REG_RANGE_END     = 3'd1,
    REG_INVERSE_WIDTH = 3'd2,
    REG_BIN_COUNT     = 3'd3,
    REG_SAMPLE_STEP   = 3'd4
  } cfg_reg_t;

  // What the back end has to do with one word
  typedef enum logic [1:0] {
    WK_EMPTY = 2'd0,
    WK_ADD   = 2'd1,
    WK_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [BIN_W-1:0] bin;
  } work_t;

  typedef struct packed {
    logic               accepted;
    logic [BIN_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
  } result_t;

  // Handshake between front end and work queue
  typedef struct packed {
    logic  push;
    work_t word;
  } q_wr_t;

endpackage

FILE: hw/rtl/rgh_front.sv
// Front end of the histogram: configuration registers, step phase and the
// three-stage bin computation pipeline. Depends on rgh_pkg.
module rgh_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [rgh_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rgh_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_push,
  input  logic [1:0]                            in_operation,
  input  logic signed [rgh_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                  in_sample_invalid,
  input  logic [rgh_pkg::BIN_W-1:0]             in_bin_index,
  input  logic                                  hold,
  input  logic                                  q_full,
  output logic                                  full,
  output rgh_pkg::q_wr_t                        q_wr
);

  logic signed [rgh_pkg::EDGE_W-1:0]  start_r, end_r;
  logic [rgh_pkg::IW_W-1:0]           iw_r;
  logic [rgh_pkg::BIN_COUNT_W-1:0]    nbins_r;
  logic [rgh_pkg::STEP_W-1:0]         step_r;
  logic [rgh_pkg::STEP_W-1:0]         phase_r, phase_nxt;

  logic en, accept;

  // stage 1: raw item
  logic                                 s1_v_r;
  rgh_pkg::op_t                         s1_op_r;
  logic signed [rgh_pkg::SAMPLE_W-1:0]  s1_sample_r;
  logic                                 s1_take_r;
  logic [rgh_pkg::BIN_W-1:0]            s1_idx_r;

  // stage 2: offset from start
  logic                                 s2_v_r;
  rgh_pkg::op_t                         s2_op_r;
  logic                                 s2_take_r;
  logic                                 s2_is_end_r;
  logic [rgh_pkg::EDGE_W-1:0]           s2_d_r;
  logic [rgh_pkg::BIN_W-1:0]            s2_idx_r;

  // stage 3: raw bin number
  logic                                 s3_v_r;
  rgh_pkg::op_t                         s3_op_r;
  logic                                 s3_take_r;
  logic                                 s3_is_end_r;
  logic [rgh_pkg::IW_W-1:0]             s3_b_r;
  logic [rgh_pkg::BIN_W-1:0]            s3_idx_r;

  logic [rgh_pkg::STEP_W-1:0]           step_eff;
  logic [rgh_pkg::STEP_W:0]             phase_inc;
  logic                                 in_range;
  logic [rgh_pkg::EDGE_W:0]             diff;
  logic [2*rgh_pkg::IW_W-1:0]           prod;
  logic [rgh_pkg::BIN_COUNT_W-1:0]      nb_eff;
  logic                                 over;
  rgh_pkg::work_t                       word;

  // the pipeline moves as one; it stops only when a finished word cannot enter the queue
  assign en     = !(s3_v_r && q_full);
  assign full   = hold || !en;
  assign accept = in_push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= rgh_pkg::START_RST;
      end_r   <= rgh_pkg::END_RST;
      iw_r    <= rgh_pkg::IW_RST;
      nbins_r <= rgh_pkg::BIN_COUNT_RST;
      step_r  <= rgh_pkg::STEP_RST;
    end else if (cfg_valid) begin
      unique case (rgh_pkg::cfg_reg_t'(cfg_index))
        rgh_pkg::REG_RANGE_START:   start_r <= cfg_data[rgh_pkg::EDGE_W-1:0];
        rgh_pkg::REG_RANGE_END:     end_r   <= cfg_data[rgh_pkg::EDGE_W-1:0];
        rgh_pkg::REG_INVERSE_WIDTH: iw_r    <= cfg_data[rgh_pkg::IW_W-1:0];
        rgh_pkg::REG_BIN_COUNT:     nbins_r <= cfg_data[rgh_pkg::BIN_COUNT_W-1:0];
        rgh_pkg::REG_SAMPLE_STEP:   step_r  <= cfg_data[rgh_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // step phase advances on every sample word, even a rejected one
  always_comb begin
    step_eff  = (step_r == '0) ? rgh_pkg::STEP_W'(1) : step_r;
    phase_inc = {1'b0, phase_r} + (rgh_pkg::STEP_W+1)'(1);
    phase_nxt = phase_r;
    if (accept) begin
      unique case (rgh_pkg::op_t'(in_operation))
        rgh_pkg::OP_ADD:
          phase_nxt = (phase_inc >= {1'b0, step_eff}) ? '0 : phase_inc[rgh_pkg::STEP_W-1:0];
        rgh_pkg::OP_RESTART: phase_nxt = '0;
        rgh_pkg::OP_READ, rgh_pkg::OP_UNUSED: phase_nxt = phase_r;
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_comb begin
    in_range = !(s1_sample_r < start_r) && !(s1_sample_r > end_r);
    diff     = {s1_sample_r[rgh_pkg::SAMPLE_W-1], s1_sample_r} - {start_r[rgh_pkg::EDGE_W-1], start_r};
    prod     = {{rgh_pkg::IW_W{1'b0}}, s2_d_r} * {{rgh_pkg::EDGE_W{1'b0}}, iw_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r     <= rgh_pkg::op_t'(in_operation);
      s1_sample_r <= in_sample;
      s1_take_r   <= (phase_r == '0) && !in_sample_invalid;
      s1_idx_r    <= in_bin_index;

      s2_op_r     <= s1_op_r;
      s2_take_r   <= s1_take_r && in_range;
      s2_is_end_r <= (s1_sample_r == end_r);
      s2_d_r      <= diff[rgh_pkg::EDGE_W-1:0];
      s2_idx_r    <= s1_idx_r;

      s3_op_r     <= s2_op_r;
      s3_take_r   <= s2_take_r;
      s3_is_end_r <= s2_is_end_r;
      s3_b_r      <= prod[2*rgh_pkg::IW_W-1:rgh_pkg::IW_W];
      s3_idx_r    <= s2_idx_r;
    end
  end

  // clamp the bin count, fold the top edge into the last bin
  always_comb begin
    if (nbins_r == '0) begin
      nb_eff = rgh_pkg::BIN_COUNT_W'(1);
    end else if (nbins_r > rgh_pkg::MAX_BINS_C) begin
      nb_eff = rgh_pkg::MAX_BINS_C;
    end else begin
      nb_eff = nbins_r;
    end
    over      = s3_b_r >= {{(rgh_pkg::IW_W-rgh_pkg::BIN_COUNT_W){1'b0}}, nb_eff};
    word.kind = rgh_pkg::WK_EMPTY;
    word.bin  = '0;
    unique case (s3_op_r)
      rgh_pkg::OP_ADD: begin
        if (s3_take_r && (!over || s3_is_end_r)) begin
          word.kind = rgh_pkg::WK_ADD;
          word.bin  = over ? rgh_pkg::BIN_W'(nb_eff - rgh_pkg::BIN_COUNT_W'(1))
                           : s3_b_r[rgh_pkg::BIN_W-1:0];
        end
      end
      rgh_pkg::OP_READ: begin
        word.kind = rgh_pkg::WK_READ;
        word.bin  = s3_idx_r;
      end
      rgh_pkg::OP_RESTART, rgh_pkg::OP_UNUSED: word.kind = rgh_pkg::WK_EMPTY;
      default: word.kind = rgh_pkg::WK_EMPTY;
    endcase
  end

  assign q_wr.push = s3_v_r && en;
  assign q_wr.word = word;

endmodule

FILE: hw/rtl/rgh_queue.sv
// Short work queue between the front end and the back end.
// Depends on rgh_pkg for the word type and depth.
module rgh_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  rgh_pkg::q_wr_t  q_wr,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output rgh_pkg::work_t  head
);

  rgh_pkg::work_t            mem_r [rgh_pkg::Q_DEPTH];
  logic [rgh_pkg::Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [rgh_pkg::Q_AW:0]    cnt_r;
  logic                      do_push, do_pop;

  assign full    = (cnt_r == (rgh_pkg::Q_AW+1)'(rgh_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = q_wr.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + rgh_pkg::Q_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + rgh_pkg::Q_AW'(1);
      cnt_r <= cnt_r + (rgh_pkg::Q_AW+1)'(do_push) - (rgh_pkg::Q_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_wr.word;
  end

endmodule

FILE: hw/rtl/rgh_back.sv
// Back end of the histogram: count memory with its clearing pass, the
// read-modify-write sequencer and the result buffer. Depends on rgh_pkg.
module rgh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rgh_pkg::work_t      q_head,
  output logic                q_pop,
  output logic                clear_busy,
  input  logic                out_pop,
  output logic                out_empty,
  output rgh_pkg::result_t    out_word
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [rgh_pkg::COUNT_W-1:0] mem [rgh_pkg::MAX_BINS];
  logic                        mem_we, mem_re;
  logic [rgh_pkg::BIN_W-1:0]   mem_wa, mem_ra;
  logic [rgh_pkg::COUNT_W-1:0] mem_wd, rd_r;

  logic [rgh_pkg::BIN_W-1:0]   clr_addr_r, clr_addr_nxt;
  rgh_pkg::work_t              cur_r, cur_nxt;

  rgh_pkg::result_t            ob_r [rgh_pkg::OUT_DEPTH];
  logic [rgh_pkg::OUT_AW-1:0]  ob_wr_r, ob_rd_r;
  logic [rgh_pkg::OUT_AW:0]    ob_cnt_r;
  logic                        ob_full, ob_push, ob_pop;
  rgh_pkg::result_t            res;

  assign ob_full    = (ob_cnt_r == (rgh_pkg::OUT_AW+1)'(rgh_pkg::OUT_DEPTH));
  assign out_empty  = (ob_cnt_r == '0);
  assign ob_pop     = out_pop && !out_empty;
  assign out_word   = ob_r[ob_rd_r];
  assign clear_busy = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cur_nxt      = cur_r;
    mem_we       = 1'b0;
    mem_wa       = cur_r.bin;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = q_head.bin;
    q_pop        = 1'b0;
    ob_push      = 1'b0;
    res          = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        clr_addr_nxt = clr_addr_r + rgh_pkg::BIN_W'(1);
        if (clr_addr_r == {rgh_pkg::BIN_W{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        // take a word only when its result has a place to go
        if (!q_empty && !ob_full) begin
          q_pop = 1'b1;
          if (q_head.kind == rgh_pkg::WK_EMPTY) begin
            ob_push = 1'b1;
          end else begin
            mem_re    = 1'b1;
            cur_nxt   = q_head;
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        mem_we  = 1'b1;
        ob_push = 1'b1;
        res.bin = cur_r.bin;
        if (cur_r.kind == rgh_pkg::WK_ADD) begin
          mem_wd       = (rd_r == rgh_pkg::CNT_MAX) ? rd_r : rd_r + rgh_pkg::COUNT_W'(1);
          res.accepted = 1'b1;
        end else begin
          res.count = rd_r;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= '0;
      ob_rd_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      if (ob_push) ob_wr_r <= ob_wr_r + rgh_pkg::OUT_AW'(1);
      if (ob_pop)  ob_rd_r <= ob_rd_r + rgh_pkg::OUT_AW'(1);
      ob_cnt_r <= ob_cnt_r + (rgh_pkg::OUT_AW+1)'(ob_push) - (rgh_pkg::OUT_AW+1)'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) ob_r[ob_wr_r] <= res;
  end

  a_update_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> ($past(state_r) == ST_IDLE))
    else $error("update without a preceding read");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ob_push |-> (ob_cnt_r < (rgh_pkg::OUT_AW+1)'(rgh_pkg::OUT_DEPTH)))
    else $error("result buffer overflow");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !q_pop)
    else $error("work taken during clearing pass");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("work queue popped while empty");

endmodule

FILE: hw/rtl/regular_grid_histogram.sv
// Top level of the regular grid histogram: front end, work queue, back end.
// Depends on rgh_pkg, rgh_front, rgh_queue and rgh_back.

// After reset the block runs a clearing pass over all 4096 words of the count
// memory, during which in_full stays high; configuration writes are taken at
// any time out of reset. A word travels three front-end stages (range check,
// bin multiply, bin clamp) and then waits in a four-word queue for the back
// end. The back end works on the single-port count memory: a sample that is
// counted is read and then written back one higher (saturating), a bin read is
// read and then written back as zero, and a word whose result is all zeros
// goes straight to the result buffer. The back end takes no new word from the
// queue until it has written back the last one; skipped samples need no
// memory access.
module regular_grid_histogram (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rgh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rgh_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [1:0]                           in_operation,
  input  logic signed [rgh_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_sample_invalid,
  input  logic [rgh_pkg::BIN_W-1:0]            in_bin_index,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic                                 out_accepted,
  output logic [rgh_pkg::BIN_W-1:0]            out_result_bin,
  output logic [rgh_pkg::COUNT_W-1:0]          out_count
);

  rgh_pkg::q_wr_t   q_wr;
  rgh_pkg::work_t   q_head;
  rgh_pkg::result_t res;
  logic             q_full, q_empty, q_pop, clear_busy;

  // registers load on any cycle out of reset
  assign cfg_ready = rst_n;

  rgh_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_operation      (in_operation),
    .in_sample         (in_sample),
    .in_sample_invalid (in_sample_invalid),
    .in_bin_index      (in_bin_index),
    .hold              (clear_busy),
    .q_full            (q_full),
    .full              (in_full),
    .q_wr              (q_wr)
  );

  rgh_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  rgh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_word   (res)
  );

  assign out_accepted   = res.accepted;
  assign out_result_bin = res.bin;
  assign out_count      = res.count;

endmodule
